FILE: rtl/lkvt_pkg.sv
// Shared constants and codes for the linear key/value table.
// No dependencies; every other file of the block imports this package.
package lkvt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int MODE_W  = 2;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int INDEX_W = 4;
    localparam int STAT_W  = 3;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int REG_W   = ADDR_W - 2;

    localparam logic [REG_W-1:0] REG_CAPACITY = REG_W'(0);
    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd4;

endpackage

FILE: rtl/lkvt_if.sv
// Valid/ready channels for table requests and results.
// Depends on lkvt_pkg for field widths.
interface lkvt_req_if;
    import lkvt_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    value;
    logic [INDEX_W-1:0]  index;

    modport source (output valid, mode, key, value, index, input ready);
    modport sink   (input valid, mode, key, value, index, output ready);
endinterface

interface lkvt_rsp_if;
    import lkvt_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic                found;
    logic [KEY_W-1:0]    result_key;
    logic [VAL_W-1:0]    result_value;
    logic [CNT_W-1:0]    entry_count;

    modport source (output valid, status, found, result_key, result_value, entry_count,
                    input ready);
    modport sink   (input valid, status, found, result_key, result_value, entry_count,
                    output ready);
endinterface

FILE: rtl/linear_key_value_table.sv
// Linear key/value table: request sequencer, entry memory and scan compare unit.
// Depends on lkvt_pkg, lkvt_if and lkvt_cfg.
//
// A dense table of up to 16 key/value pairs in insertion order. Insert and
// read-at-index go from idle to the result state, which loads the output
// register once it is free. Remove and lookup walk every stored entry through
// the single memory read port and one key comparator, one entry a cycle, and
// then pass through the result state as well. No request is taken while another
// is in progress: a new request is taken once the sequencer is back in idle,
// even while the previous result still waits in the output register. Capacity
// is written over the APB port at byte address 0 and should only change while
// idle.
module linear_key_value_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkvt_pkg::ADDR_W-1:0]   paddr,
    input  logic [lkvt_pkg::DATA_W-1:0]   pwdata,
    output logic [lkvt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    lkvt_req_if.sink                      i_req,
    lkvt_rsp_if.source                    o_rsp
);
    import lkvt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESULT} t_state;

    t_state             r_state;
    logic [CAP_W-1:0]   w_capacity;

    logic [KEY_W-1:0]   r_mem_key [ENTRIES];
    logic [VAL_W-1:0]   r_mem_val [ENTRIES];
    logic [KEY_W-1:0]   r_rd_key;
    logic [VAL_W-1:0]   r_rd_val;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_rd_idx;
    logic [CNT_W-1:0]   r_kept;
    logic               r_dv;
    logic [MODE_W-1:0]  r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [STAT_W-1:0]  r_status;
    logic               r_found;
    logic [KEY_W-1:0]   r_res_key;
    logic [VAL_W-1:0]   r_res_val;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_o_status;
    logic               r_o_found;
    logic [KEY_W-1:0]   r_o_key;
    logic [VAL_W-1:0]   r_o_val;
    logic [CNT_W-1:0]   r_o_count;

    logic               w_accept;
    logic               w_full;
    logic [CMP_W-1:0]   w_eff_cap;
    logic               w_rd_more;
    logic               w_match;
    logic               w_scan_done;
    logic               w_out_range;
    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [KEY_W-1:0]   w_wr_key;
    logic [VAL_W-1:0]   w_wr_val;

    lkvt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_capacity)
    );

    assign i_req.ready        = (r_state == S_IDLE);
    assign w_accept           = i_req.valid && i_req.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.found        = r_o_found;
    assign o_rsp.result_key   = r_o_key;
    assign o_rsp.result_value = r_o_val;
    assign o_rsp.entry_count  = r_o_count;

    // Capacity above the table size acts as the table size.
    assign w_eff_cap   = (CMP_W'(w_capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                               : CMP_W'(w_capacity);
    assign w_full      = (CMP_W'(r_count) >= w_eff_cap);
    assign w_out_range = (CNT_W'(i_req.index) >= r_count);

    assign w_rd_more   = (r_rd_idx < r_count);
    assign w_match     = (r_rd_key == r_key);
    assign w_scan_done = (r_state == S_SCAN) && !w_rd_more && !r_dv;

    assign w_rd_en   = (w_accept && (i_req.mode == MODE_READ))
                    || ((r_state == S_SCAN) && w_rd_more);
    assign w_rd_addr = (r_state == S_IDLE) ? i_req.index[IDX_W-1:0] : r_rd_idx[IDX_W-1:0];

    // Compaction writes survivors at the kept position, always behind the read pointer.
    assign w_wr_en   = (w_accept && (i_req.mode == MODE_INSERT) && !w_full)
                    || ((r_state == S_SCAN) && r_dv && !w_match && (r_mode == MODE_REMOVE));
    assign w_wr_addr = (r_state == S_IDLE) ? r_count[IDX_W-1:0] : r_kept[IDX_W-1:0];
    assign w_wr_key  = (r_state == S_IDLE) ? i_req.key   : r_rd_key;
    assign w_wr_val  = (r_state == S_IDLE) ? i_req.value : r_rd_val;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_key[w_wr_addr] <= w_wr_key;
            r_mem_val[w_wr_addr] <= w_wr_val;
        end
        if (w_rd_en) begin
            r_rd_key <= r_mem_key[w_rd_addr];
            r_rd_val <= r_mem_val[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode    <= i_req.mode;
                        r_key     <= i_req.key;
                        r_rd_idx  <= '0;
                        r_kept    <= '0;
                        r_dv      <= 1'b0;
                        r_found   <= 1'b0;
                        r_res_key <= '0;
                        r_res_val <= '0;
                        r_status  <= STAT_OK;
                        case (i_req.mode)
                            MODE_INSERT: begin
                                if (w_full) begin
                                    r_status <= STAT_FULL;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                                r_state <= S_RESULT;
                            end
                            MODE_READ: begin
                                if (w_out_range) begin
                                    r_status <= STAT_RANGE;
                                end else begin
                                    r_found <= 1'b1;
                                end
                                r_state <= S_RESULT;
                            end
                            default: begin
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_dv <= w_rd_more;
                    if (w_rd_more) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (r_dv) begin
                        // keep only the first hit of a lookup
                        if (w_match && !r_found && (r_mode == MODE_LOOKUP)) begin
                            r_found   <= 1'b1;
                            r_res_key <= r_rd_key;
                            r_res_val <= r_rd_val;
                        end
                        if (!w_match) begin
                            r_kept <= r_kept + 1'b1;
                        end
                    end
                    if (w_scan_done) begin
                        r_state <= S_RESULT;
                        if (r_mode == MODE_REMOVE) begin
                            r_count <= r_kept;
                            if (r_count == '0) begin
                                r_status <= STAT_EMPTY;
                            end else if (r_kept == r_count) begin
                                r_status <= STAT_NOT_FOUND;
                            end else begin
                                r_status <= STAT_OK;
                            end
                        end else begin
                            r_status <= r_found ? STAT_OK : STAT_NOT_FOUND;
                        end
                    end
                end
                S_RESULT: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_found   <= r_found;
                        r_o_key     <= ((r_mode == MODE_READ) && r_found) ? r_rd_key
                                                                          : r_res_key;
                        r_o_val     <= ((r_mode == MODE_READ) && r_found) ? r_rd_val
                                                                          : r_res_val;
                        r_o_count   <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count exceeds table size");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.mode == MODE_INSERT) && !w_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted insert did not grow the table");

    a_only_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_accept && (i_req.mode == MODE_INSERT)) |=> (r_count <= $past(r_count)))
        else $error("entry count grew without an insert");

    a_kept_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_kept <= r_rd_idx))
        else $error("compaction write passed the read pointer");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESULT) && r_out_valid && !o_rsp.ready)
        |=> ((r_state == S_RESULT) && $stable(r_o_status)))
        else $error("result overwrote an untaken output");
`endif

endmodule

FILE: rtl/lkvt_cfg.sv
// APB-style register file holding the capacity register.
// Depends on lkvt_pkg for address and register widths.
module lkvt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lkvt_pkg::ADDR_W-1:0]   paddr,
    input  logic [lkvt_pkg::DATA_W-1:0]   pwdata,
    output logic [lkvt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [lkvt_pkg::CAP_W-1:0]    o_capacity
);
    import lkvt_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             w_sel_cap;

    assign w_sel_cap  = (paddr[ADDR_W-1:2] == REG_CAPACITY);
    assign pready     = 1'b1;
    assign prdata     = w_sel_cap ? DATA_W'(r_capacity) : '0;
    assign o_capacity = r_capacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_cap) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

endmodule
